// File: rtl/core/flks_pkg.sv
// ----------------------------------------------------------------------------
// flks_pkg
// Shared types and constants of the filtered lowest-K selector: field widths,
// configuration register codes, reset values and the queued item record.
// ----------------------------------------------------------------------------
package flks_pkg;

	// Field widths.
	localparam int ENERGY_W = 32;
	localparam int INDEX_W  = 32;
	localparam int OCC_W    = 64;
	localparam int SELECT_COUNT_W = 6;

	// Configuration port shape.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// Configuration register codes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SELECT_COUNT = 2'd0,
		CFG_CORE_FILTER  = 2'd1,
		CFG_CORE_MASK    = 2'd2
	} cfg_reg_t;

	// Register reset values.
	localparam logic [SELECT_COUNT_W-1:0] SELECT_COUNT_RST = 6'd8;
	localparam logic                      CORE_FILTER_RST  = 1'b0;
	localparam logic [OCC_W-1:0]          CORE_MASK_RST    = '0;

	// Energy shown by an unfilled slot: the most positive key.
	localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = 32'sh7FFF_FFFF;

	// Depth of the queue between the classifier and the table.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	// One classified candidate on its way to the table.
	typedef struct packed {
		logic signed [ENERGY_W-1:0] energy;
		logic [INDEX_W-1:0]         det_index;
		logic                       keep;
		logic                       last;
	} item_t;

endpackage

// File: rtl/core/flks_in_if.sv
// ----------------------------------------------------------------------------
// flks_in_if
// Candidate channel: valid/ready handshake with the candidate word.
// ----------------------------------------------------------------------------
interface flks_in_if;

	logic                                 valid;
	logic                                 ready;
	logic signed [flks_pkg::ENERGY_W-1:0] energy;
	logic [flks_pkg::INDEX_W-1:0]         det_index;
	logic [flks_pkg::OCC_W-1:0]           alpha_occupancy;
	logic [flks_pkg::OCC_W-1:0]           beta_occupancy;
	logic                                 last_item;

	modport source (
		output valid, energy, det_index, alpha_occupancy, beta_occupancy, last_item,
		input  ready
	);

	modport sink (
		input  valid, energy, det_index, alpha_occupancy, beta_occupancy, last_item,
		output ready
	);

endinterface

// File: rtl/core/flks_out_if.sv
// ----------------------------------------------------------------------------
// flks_out_if
// Selection channel: valid/ready handshake with one selected slot per word.
// ----------------------------------------------------------------------------
interface flks_out_if;

	logic                                 valid;
	logic                                 ready;
	logic [flks_pkg::INDEX_W-1:0]         sel_index;
	logic signed [flks_pkg::ENERGY_W-1:0] sel_energy;
	logic                                 sel_valid;
	logic                                 last_result;

	modport source (
		output valid, sel_index, sel_energy, sel_valid, last_result,
		input  ready
	);

	modport sink (
		input  valid, sel_index, sel_energy, sel_valid, last_result,
		output ready
	);

endinterface

// File: rtl/core/flks_front.sv
// ----------------------------------------------------------------------------
// flks_front
// Accepts candidate words and classifies them: applies the core-orbital
// filter and pushes the reduced record into the queue.
// ----------------------------------------------------------------------------
module flks_front #(
	parameter int NUM_ORBITALS = 64
) (
	flks_in_if.sink                   in,
	input  logic                      core_filter_enable,
	input  logic [flks_pkg::OCC_W-1:0] core_mask,
	output logic                      push_valid,
	output flks_pkg::item_t           push_item,
	input  logic                      push_ready
);

	logic [NUM_ORBITALS-1:0] singly;
	logic                    one_single;

	// Singly occupied orbitals; bits beyond the orbital count are dropped.
	assign singly = in.alpha_occupancy[NUM_ORBITALS-1:0]
		^ in.beta_occupancy[NUM_ORBITALS-1:0];

	// Exactly one singly occupied core orbital.
	always_comb begin
		logic [NUM_ORBITALS-1:0] core_single;
		core_single = singly & core_mask[NUM_ORBITALS-1:0];
		one_single = (core_single != '0)
			&& ((core_single & (core_single - NUM_ORBITALS'(1))) == '0);
	end

	// A word is taken whenever the queue has room.
	assign in.ready   = push_ready;
	assign push_valid = in.valid;

	always_comb begin
		push_item.energy    = in.energy;
		push_item.det_index = in.det_index;
		push_item.keep      = core_filter_enable ? one_single : 1'b1;
		push_item.last      = in.last_item;
	end

endmodule

// File: rtl/core/flks_queue.sv
// ----------------------------------------------------------------------------
// flks_queue
// Short first-in first-out queue between the classifier and the table, so
// that each side stalls on its own.
// ----------------------------------------------------------------------------
module flks_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  flks_pkg::item_t push_item,
	output logic            push_ready,
	output logic            pop_valid,
	output flks_pkg::item_t pop_item,
	input  logic            pop
);

	flks_pkg::item_t                    entry_q [flks_pkg::QUEUE_DEPTH];
	logic [flks_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [flks_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [flks_pkg::QUEUE_CNT_W-1:0]   count_q;
	logic                               do_push;
	logic                               do_pop;

	assign push_ready = (count_q != flks_pkg::QUEUE_CNT_W'(flks_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: rtl/core/flks_back.sv
// ----------------------------------------------------------------------------
// flks_back
// Sorted slot row. Every slot compares the incoming key in parallel and
// either holds, takes the new candidate or takes its left neighbor. On a
// last item the row is shifted out from slot 0 through the output register.
// ----------------------------------------------------------------------------
module flks_back #(
	parameter int MAX_SELECT = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [flks_pkg::SELECT_COUNT_W-1:0]   select_count,
	input  logic                                  q_valid,
	input  flks_pkg::item_t                       q_item,
	output logic                                  q_pop,
	flks_out_if.source                            out
);

	localparam int KW = $clog2(MAX_SELECT + 1);

	typedef enum logic {
		ST_RUN,
		ST_EMIT
	} state_t;

	state_t                              state_q;
	logic [KW-1:0]                       emit_cnt_q;
	logic                                out_valid_q;
	logic [flks_pkg::INDEX_W-1:0]        out_index_q;
	logic signed [flks_pkg::ENERGY_W-1:0] out_energy_q;
	logic                                out_sel_valid_q;
	logic                                out_last_q;

	logic signed [flks_pkg::ENERGY_W-1:0] slot_energy_q [MAX_SELECT];
	logic [flks_pkg::INDEX_W-1:0]         slot_index_q  [MAX_SELECT];
	logic [MAX_SELECT-1:0]                slot_filled_q;

	logic signed [flks_pkg::ENERGY_W-1:0] slot_energy_d [MAX_SELECT];
	logic [flks_pkg::INDEX_W-1:0]         slot_index_d  [MAX_SELECT];
	logic [MAX_SELECT-1:0]                slot_filled_d;

	logic [KW-1:0]         k_eff;
	logic [MAX_SELECT-1:0] in_range;
	logic [MAX_SELECT-1:0] live;
	logic [MAX_SELECT-1:0] take;
	logic [MAX_SELECT-1:0] take_left;
	logic                  proc;
	logic                  insert;
	logic                  out_free;
	logic                  emit_ld;
	logic                  emit_last;

	// Effective K: zero counts as one, large counts saturate.
	always_comb begin
		if (select_count == '0) begin
			k_eff = KW'(1);
		end else if (32'(select_count) > MAX_SELECT) begin
			k_eff = KW'(MAX_SELECT);
		end else begin
			k_eff = KW'(select_count);
		end
	end

	assign out_free  = !out_valid_q || out.ready;
	assign proc      = (state_q == ST_RUN) && q_valid;
	assign q_pop     = proc;
	assign insert    = proc && q_item.keep;
	assign emit_ld   = (state_q == ST_EMIT) && out_free;
	assign emit_last = (emit_cnt_q == k_eff - KW'(1));

	// Per-slot compare. The take vector is a thermometer: filled slots are
	// sorted, and every empty slot takes.
	always_comb begin
		for (int i = 0; i < MAX_SELECT; i++) begin
			in_range[i] = (KW'(i) < k_eff);
			live[i]     = slot_filled_q[i] && in_range[i];
			take[i]     = !live[i] || (q_item.energy < slot_energy_q[i]);
		end
		take_left[0] = 1'b0;
		for (int i = 1; i < MAX_SELECT; i++) begin
			take_left[i] = take[i-1];
		end
	end

	// Next slot contents.
	always_comb begin
		for (int i = 0; i < MAX_SELECT; i++) begin
			slot_energy_d[i] = slot_energy_q[i];
			slot_index_d[i]  = slot_index_q[i];
			slot_filled_d[i] = slot_filled_q[i];
		end
		if (proc) begin
			// Insert at the first taking slot; later slots take their left neighbor.
			for (int i = 0; i < MAX_SELECT; i++) begin
				slot_filled_d[i] = live[i];
				if (insert && take[i] && !take_left[i]) begin
					slot_energy_d[i] = q_item.energy;
					slot_index_d[i]  = q_item.det_index;
					slot_filled_d[i] = 1'b1;
				end
			end
			for (int i = 1; i < MAX_SELECT; i++) begin
				if (insert && take_left[i]) begin
					slot_energy_d[i] = slot_energy_q[i-1];
					slot_index_d[i]  = slot_index_q[i-1];
					slot_filled_d[i] = live[i-1];
				end
			end
			// Slots beyond K are dropped.
			for (int i = 0; i < MAX_SELECT; i++) begin
				if (!in_range[i]) begin
					slot_filled_d[i] = 1'b0;
				end
			end
		end else if (emit_ld) begin
			// Readout shifts the row toward slot 0.
			for (int i = 0; i < MAX_SELECT - 1; i++) begin
				slot_energy_d[i] = slot_energy_q[i+1];
				slot_index_d[i]  = slot_index_q[i+1];
				slot_filled_d[i] = slot_filled_q[i+1];
			end
			slot_filled_d[MAX_SELECT-1] = 1'b0;
			if (emit_last) begin
				slot_filled_d = '0;
			end
		end
	end

	// Slot payload.
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_SELECT; i++) begin
			slot_energy_q[i] <= slot_energy_d[i];
			slot_index_q[i]  <= slot_index_d[i];
		end
	end

	// Slot occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_filled_q <= '0;
		end else begin
			slot_filled_q <= slot_filled_d;
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (out.ready) begin
						out_valid_q <= 1'b0;
					end
					if (proc && q_item.last) begin
						state_q    <= ST_EMIT;
						emit_cnt_q <= '0;
					end
				end
				ST_EMIT: begin
					if (emit_ld) begin
						out_valid_q <= 1'b1;
						emit_cnt_q  <= emit_cnt_q + KW'(1);
						if (emit_last) begin
							state_q <= ST_RUN;
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// Output word payload: an unfilled slot shows index zero and the top key.
	always_ff @(posedge clk) begin
		if (emit_ld) begin
			out_sel_valid_q <= slot_filled_q[0];
			out_index_q     <= slot_filled_q[0] ? slot_index_q[0] : '0;
			out_energy_q    <= slot_filled_q[0] ? slot_energy_q[0] : flks_pkg::ENERGY_MAX;
			out_last_q      <= emit_last;
		end
	end

	assign out.valid       = out_valid_q;
	assign out.sel_index   = out_index_q;
	assign out.sel_energy  = out_energy_q;
	assign out.sel_valid   = out_sel_valid_q;
	assign out.last_result = out_last_q;

endmodule

// File: rtl/core/filtered_lowest_k_selector_core.sv
// ----------------------------------------------------------------------------
// filtered_lowest_k_selector_core
// Keeps the K lowest-energy candidates of a stream in a sorted slot row,
// optionally filtered on core-orbital single occupancy, and reads the row
// out in ascending order when the last candidate arrives.
//
//   Channel  Direction  Handshake     Word
//   in       sink       valid/ready   energy, det_index, occupancies, last_item
//   out      source     valid/ready   sel_index, sel_energy, sel_valid, last_result
//   cfg      sink       cfg_wr_en     cfg_index, cfg_wr_data
//
// Outside readout the row takes one candidate per cycle; all slots compare at once.
// A last candidate is followed by a readout of K words, during which the row
// shifts toward slot 0 and the queue (four words) keeps absorbing input.
// An output stall holds the readout; a full queue then drops in.ready.
// Reset clears the queue and slot occupancy and loads register defaults at once.
// ----------------------------------------------------------------------------
module filtered_lowest_k_selector_core #(
	parameter int MAX_SELECT   = 32,
	parameter int NUM_ORBITALS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	flks_in_if.sink                           in,
	flks_out_if.source                        out,
	input  logic                              cfg_wr_en,
	input  logic [flks_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [flks_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

	logic [flks_pkg::SELECT_COUNT_W-1:0] select_count_q;
	logic                                core_filter_enable_q;
	logic [flks_pkg::OCC_W-1:0]          core_mask_q;

	logic            push_valid;
	logic            push_ready;
	flks_pkg::item_t push_item;
	logic            q_valid;
	logic            q_pop;
	flks_pkg::item_t q_item;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_count_q       <= flks_pkg::SELECT_COUNT_RST;
			core_filter_enable_q <= flks_pkg::CORE_FILTER_RST;
			core_mask_q          <= flks_pkg::CORE_MASK_RST;
		end else if (cfg_wr_en) begin
			unique case (flks_pkg::cfg_reg_t'(cfg_index))
				flks_pkg::CFG_SELECT_COUNT: begin
					select_count_q <= cfg_wr_data[flks_pkg::SELECT_COUNT_W-1:0];
				end
				flks_pkg::CFG_CORE_FILTER: begin
					core_filter_enable_q <= cfg_wr_data[0];
				end
				flks_pkg::CFG_CORE_MASK: begin
					core_mask_q <= cfg_wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Classifier.
	flks_front #(
		.NUM_ORBITALS (NUM_ORBITALS)
	) u_front (
		.in                 (in),
		.core_filter_enable (core_filter_enable_q),
		.core_mask          (core_mask_q),
		.push_valid         (push_valid),
		.push_item          (push_item),
		.push_ready         (push_ready)
	);

	// Decoupling queue.
	flks_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_item   (q_item),
		.pop        (q_pop)
	);

	// Slot row and readout.
	flks_back #(
		.MAX_SELECT (MAX_SELECT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.select_count (select_count_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.out          (out)
	);

endmodule

// File: rtl/core/flks_checker.sv
// ----------------------------------------------------------------------------
// flks_checker
// Port-level checks of the selector: output word hold under stall, the
// unfilled-slot word, and unfilled slots trailing filled ones.
// ----------------------------------------------------------------------------
module flks_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [flks_pkg::INDEX_W-1:0]         sel_index,
	input logic signed [flks_pkg::ENERGY_W-1:0] sel_energy,
	input logic                                 sel_valid,
	input logic                                 last_result
);

	// A stalled output word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sel_index)
			&& $stable(sel_energy) && $stable(sel_valid) && $stable(last_result))
		else $error("output word changed while stalled");

	// An unfilled slot reads as index zero with the top key.
	a_unfilled_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sel_valid |-> sel_index == '0 && sel_energy == flks_pkg::ENERGY_MAX)
		else $error("unfilled slot word carries data");

	// Within one selection, no filled slot follows an unfilled one.
	a_unfilled_trail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !sel_valid && !last_result |=> !out_valid || !sel_valid)
		else $error("filled slot after an unfilled slot");

endmodule

bind filtered_lowest_k_selector_core flks_checker u_flks_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out.valid),
	.out_ready   (out.ready),
	.sel_index   (out.sel_index),
	.sel_energy  (out.sel_energy),
	.sel_valid   (out.sel_valid),
	.last_result (out.last_result)
);
